>>> sv/guest_csr_trap_emulator_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the guest CSR trap emulator
// ----------------------------------------------------------------------------
`ifndef GUEST_CSR_TRAP_EMULATOR_CORE_MACROS_SVH
`define GUEST_CSR_TRAP_EMULATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define GCTE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gcte assertion failed");

// Next-cycle implication, disabled during reset
`define GCTE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gcte assertion failed");

`endif

>>> sv/gcte_pkg.sv
// ----------------------------------------------------------------------------
// gcte_pkg
// Shared types, codes and CSR tables of the guest CSR trap emulator.
// ----------------------------------------------------------------------------
package gcte_pkg;

  localparam int PMP_ENTRIES_DEF = 2;
  localparam int CSR_COUNT       = 41;
  localparam int SLOT_W          = 6;

  // Opcodes (funct3)
  localparam logic [2:0] OP_SYSTEM = 3'd0;
  localparam logic [2:0] OP_CSRW   = 3'd1;
  localparam logic [2:0] OP_CSRR   = 3'd2;

  // System addresses
  localparam logic [11:0] SYS_ECALL = 12'h000;
  localparam logic [11:0] SYS_SRET  = 12'h102;
  localparam logic [11:0] SYS_MRET  = 12'h302;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_PRIV_LOW  = 3'd2;
  localparam logic [2:0] ST_ZERO_VEND = 3'd3;
  localparam logic [2:0] ST_STVEC_Z   = 3'd4;
  localparam logic [2:0] ST_RET_PRIV  = 3'd5;
  localparam logic [2:0] ST_ILLEGAL   = 3'd6;

  // Privilege modes
  localparam logic [1:0] MODE_USER    = 2'd0;
  localparam logic [1:0] MODE_SUPER   = 2'd1;
  localparam logic [1:0] MODE_MACHINE = 2'd2;

  // Slots held in dedicated registers; the PMP address slots use generic storage
  localparam logic [SLOT_W-1:0] SLOT_SSTATUS  = 6'd8;
  localparam logic [SLOT_W-1:0] SLOT_STVEC    = 6'd12;
  localparam logic [SLOT_W-1:0] SLOT_SEPC     = 6'd15;
  localparam logic [SLOT_W-1:0] SLOT_VENDOR   = 6'd20;
  localparam logic [SLOT_W-1:0] SLOT_MSTATUS  = 6'd24;
  localparam logic [SLOT_W-1:0] SLOT_MEPC     = 6'd32;
  localparam logic [SLOT_W-1:0] SLOT_PMPCFG   = 6'd38;
  localparam logic [SLOT_W-1:0] SLOT_PMPADDR0 = 6'd39;
  localparam logic [SLOT_W-1:0] SLOT_PMPADDR1 = 6'd40;

  localparam logic [63:0] VENDOR_RESET = 64'h0000_6373_6535_3336;

  // Instruction class decided by the front end
  typedef enum logic [2:0] {
    K_ECALL, K_SRET, K_MRET, K_READ, K_WRITE, K_ILLEGAL
  } kind_t;

  // Classified item handed to the back end
  typedef struct packed {
    kind_t             kind;
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic [1:0]        min_priv;
    logic [63:0]       src;
    logic [4:0]        dst;
    logic [63:0]       pc;
  } work_t;

  // Address decode; returns a found bit above the slot, all zero for an unknown address
  function automatic logic [SLOT_W:0] csr_lookup(input logic [11:0] addr);
    logic [SLOT_W:0] r;
    r = '0;
    case (addr)
      12'h000: r = {1'b1, 6'd2};
      12'h004: r = {1'b1, 6'd1};
      12'h040: r = {1'b1, 6'd3};
      12'h041: r = {1'b1, 6'd4};
      12'h042: r = {1'b1, 6'd5};
      12'h043: r = {1'b1, 6'd6};
      12'h044: r = {1'b1, 6'd7};
      12'h100: r = {1'b1, 6'd8};
      12'h102: r = {1'b1, 6'd9};
      12'h103: r = {1'b1, 6'd10};
      12'h104: r = {1'b1, 6'd11};
      12'h105: r = {1'b1, 6'd12};
      12'h106: r = {1'b1, 6'd13};
      12'h140: r = {1'b1, 6'd14};
      12'h141: r = {1'b1, 6'd15};
      12'h142: r = {1'b1, 6'd16};
      12'h143: r = {1'b1, 6'd17};
      12'h144: r = {1'b1, 6'd18};
      12'h180: r = {1'b1, 6'd19};
      12'hf11: r = {1'b1, 6'd20};
      12'hf12: r = {1'b1, 6'd21};
      12'hf13: r = {1'b1, 6'd22};
      12'hf14: r = {1'b1, 6'd23};
      12'h300: r = {1'b1, 6'd24};
      12'h301: r = {1'b1, 6'd25};
      12'h302: r = {1'b1, 6'd26};
      12'h303: r = {1'b1, 6'd27};
      12'h304: r = {1'b1, 6'd28};
      12'h305: r = {1'b1, 6'd29};
      12'h306: r = {1'b1, 6'd30};
      12'h340: r = {1'b1, 6'd31};
      12'h341: r = {1'b1, 6'd32};
      12'h342: r = {1'b1, 6'd33};
      12'h343: r = {1'b1, 6'd34};
      12'h344: r = {1'b1, 6'd35};
      12'h34a: r = {1'b1, 6'd36};
      12'h34b: r = {1'b1, 6'd37};
      12'h3a0: r = {1'b1, 6'd38};
      12'h3b0: r = {1'b1, 6'd39};
      12'h3b1: r = {1'b1, 6'd40};
      default: r = '0;
    endcase
    return r;
  endfunction

  // Minimum privilege by slot
  function automatic logic [1:0] csr_priv(input logic [SLOT_W-1:0] slot);
    logic [1:0] p;
    if (slot < 6'd8) begin
      p = MODE_USER;
    end else if (slot < 6'd21) begin
      p = MODE_SUPER;
    end else begin
      p = MODE_MACHINE;
    end
    return p;
  endfunction

endpackage

>>> sv/gcte_front.sv
// ----------------------------------------------------------------------------
// gcte_front
// Classifies an incoming trapped instruction and decodes its CSR address.
// ----------------------------------------------------------------------------
module gcte_front
  import gcte_pkg::*;
(
  input  logic [2:0]  opcode,
  input  logic [11:0] csr_addr,
  input  logic [63:0] source_value,
  input  logic [4:0]  dest_index,
  input  logic [63:0] current_pc,
  output work_t       work
);

  logic [SLOT_W:0] hit;

  // Address decode
  assign hit = csr_lookup(csr_addr);

  // Instruction class
  always_comb begin
    work.kind = K_ILLEGAL;
    case (opcode)
      OP_SYSTEM: begin
        if (csr_addr == SYS_ECALL) begin
          work.kind = K_ECALL;
        end else if (csr_addr == SYS_SRET) begin
          work.kind = K_SRET;
        end else if (csr_addr == SYS_MRET) begin
          work.kind = K_MRET;
        end
      end
      OP_CSRW: work.kind = K_WRITE;
      OP_CSRR: work.kind = K_READ;
      default: work.kind = K_ILLEGAL;
    endcase
    work.found    = hit[SLOT_W];
    work.slot     = hit[SLOT_W-1:0];
    work.min_priv = csr_priv(hit[SLOT_W-1:0]);
    work.src      = source_value;
    work.dst      = dest_index;
    work.pc       = current_pc;
  end

endmodule

>>> sv/gcte_queue.sv
// ----------------------------------------------------------------------------
// gcte_queue
// Two-entry queue of classified items between front and back end.
// ----------------------------------------------------------------------------
module gcte_queue
  import gcte_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_en,
  input  work_t wr_data,
  output logic  full,
  input  logic  rd_en,
  output work_t rd_data,
  output logic  empty
);

  work_t      entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rd_data = entry[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      entry[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, (wr_en && !full)} - {1'b0, (rd_en && !empty)};
    end
  end

endmodule

>>> sv/gcte_back.sv
// ----------------------------------------------------------------------------
// gcte_back
// Holds the guest CSR state and executes one classified item at a time.
// ----------------------------------------------------------------------------
module gcte_back
  import gcte_pkg::*;
#(
  parameter int PmpEntries = PMP_ENTRIES_DEF
)
(
  input  logic        clk,
  input  logic        rst,
  input  work_t       q_data,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status,
  output logic        killed,
  output logic        state_reset,
  output logic        write_enable,
  output logic [4:0]  write_index,
  output logic [63:0] write_value,
  output logic [63:0] next_pc,
  output logic [1:0]  privilege,
  output logic        restricted_map
);

  localparam int TorChecks = (PmpEntries < 8) ? PmpEntries : 8;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state;
  work_t  cur;
  logic   out_valid;

  // Generic CSR storage with valid bits; special slots live in registers
  logic [63:0]          mem [CSR_COUNT];
  logic [CSR_COUNT-1:0] mem_vld;
  logic [63:0]          mem_q;
  logic                 mem_vld_q;

  logic [63:0] sstatus, stvec, sepc, vendor, mstatus, mepc, pmpcfg;
  logic [1:0]  mode;
  logic        pmp_active;

  // Execute-stage results
  logic [63:0] rd_val;
  logic [63:0] cfg_new;
  logic        tor;
  logic [2:0]  st;
  logic        do_reset;
  logic        we;
  logic [63:0] npc;
  logic        csr_wr;
  logic        is_special;

  assign empty = !out_valid;
  assign q_pop = (state == S_IDLE) && !q_empty && !out_valid;

  assign is_special = (cur.slot == SLOT_SSTATUS) || (cur.slot == SLOT_STVEC) ||
                      (cur.slot == SLOT_SEPC) || (cur.slot == SLOT_VENDOR) ||
                      (cur.slot == SLOT_MSTATUS) || (cur.slot == SLOT_MEPC) ||
                      (cur.slot == SLOT_PMPCFG);

  // Read value of the addressed slot
  always_comb begin
    case (cur.slot)
      SLOT_SSTATUS: rd_val = sstatus;
      SLOT_STVEC:   rd_val = stvec;
      SLOT_SEPC:    rd_val = sepc;
      SLOT_VENDOR:  rd_val = vendor;
      SLOT_MSTATUS: rd_val = mstatus;
      SLOT_MEPC:    rd_val = mepc;
      SLOT_PMPCFG:  rd_val = pmpcfg;
      default:      rd_val = mem_vld_q ? mem_q : 64'd0;
    endcase
  end

  // TOR check over the PMP config bytes after this write
  always_comb begin
    cfg_new = (cur.slot == SLOT_PMPCFG) ? cur.src : pmpcfg;
    tor     = 1'b0;
    for (int i = 0; i < TorChecks; i++) begin
      if (cfg_new[i*8+3 +: 2] == 2'd1) begin
        tor = 1'b1;
      end
    end
  end

  // Outcome of the item
  always_comb begin
    st       = ST_OK;
    do_reset = 1'b0;
    we       = 1'b0;
    csr_wr   = 1'b0;
    npc      = cur.pc;
    case (cur.kind)
      K_ECALL: begin
        if (stvec == 64'd0) begin
          st = ST_STVEC_Z;
        end else begin
          npc = stvec;
        end
      end
      K_SRET: begin
        if (mode < MODE_SUPER) begin
          st = ST_RET_PRIV;
        end else begin
          npc = sepc;
        end
      end
      K_MRET: begin
        if (mode < MODE_MACHINE) begin
          st = ST_RET_PRIV;
        end else begin
          npc = mepc;
        end
      end
      K_READ, K_WRITE: begin
        if (!cur.found) begin
          st = ST_NOT_FOUND;
        end else if (mode < cur.min_priv) begin
          st = ST_PRIV_LOW;
        end else if (cur.kind == K_READ) begin
          we  = (cur.dst != 5'd0);
          npc = cur.pc + 64'd4;
        end else if ((cur.slot == SLOT_VENDOR) && (cur.src == 64'd0)) begin
          st = ST_ZERO_VEND;
        end else begin
          csr_wr = 1'b1;
          npc    = cur.pc + 64'd4;
        end
        do_reset = (st != ST_OK);
      end
      default: begin
        st       = ST_ILLEGAL;
        do_reset = 1'b1;
      end
    endcase
  end

  // Generic storage: registered read, write on success
  always_ff @(posedge clk) begin
    if (q_pop) begin
      mem_q <= mem[q_data.slot];
    end
    if ((state == S_EXEC) && csr_wr && !is_special) begin
      mem[cur.slot] <= cur.src;
    end
  end

  // Sequencer, architectural state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      mem_vld    <= '0;
      mem_vld_q  <= 1'b0;
      sstatus    <= 64'd0;
      stvec      <= 64'd0;
      sepc       <= 64'd0;
      vendor     <= VENDOR_RESET;
      mstatus    <= 64'd0;
      mepc       <= 64'd0;
      pmpcfg     <= 64'd0;
      mode       <= MODE_MACHINE;
      pmp_active <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            cur       <= q_data;
            mem_vld_q <= mem_vld[q_data.slot];
            state     <= S_EXEC;
          end
        end
        S_EXEC: begin
          state        <= S_IDLE;
          out_valid    <= 1'b1;
          status       <= st;
          killed       <= (st != ST_OK);
          state_reset  <= do_reset;
          write_enable <= we;
          write_index  <= we ? cur.dst : 5'd0;
          write_value  <= we ? rd_val : 64'd0;
          next_pc      <= npc;
          if (do_reset) begin
            mem_vld        <= '0;
            sstatus        <= 64'd0;
            stvec          <= 64'd0;
            sepc           <= 64'd0;
            vendor         <= VENDOR_RESET;
            mstatus        <= 64'd0;
            mepc           <= 64'd0;
            pmpcfg         <= 64'd0;
            mode           <= MODE_MACHINE;
            pmp_active     <= 1'b0;
            privilege      <= MODE_MACHINE;
            restricted_map <= 1'b0;
          end else if (st != ST_OK) begin
            privilege      <= mode;
            restricted_map <= pmp_active && (mode != MODE_MACHINE);
          end else begin
            case (cur.kind)
              K_ECALL: begin
                sepc           <= cur.pc;
                mode           <= MODE_SUPER;
                privilege      <= MODE_SUPER;
                restricted_map <= pmp_active;
              end
              K_SRET: begin
                sstatus <= {sstatus[63:9], 1'b0, sstatus[7:6], 1'b0, sstatus[4:2],
                            sstatus[1] | sstatus[5], sstatus[0]};
                mode           <= sstatus[8] ? MODE_SUPER : MODE_USER;
                privilege      <= sstatus[8] ? MODE_SUPER : MODE_USER;
                restricted_map <= pmp_active;
              end
              K_MRET: begin
                mstatus <= {mstatus[63:6], 1'b0, mstatus[4],
                            mstatus[3] | mstatus[7], mstatus[2:0]};
                mode           <= mstatus[11] ? MODE_SUPER : MODE_USER;
                privilege      <= mstatus[11] ? MODE_SUPER : MODE_USER;
                restricted_map <= pmp_active;
              end
              default: begin
                privilege      <= mode;
                restricted_map <= pmp_active && (mode != MODE_MACHINE);
                if (csr_wr) begin
                  case (cur.slot)
                    SLOT_SSTATUS: sstatus <= cur.src;
                    SLOT_STVEC:   stvec   <= cur.src;
                    SLOT_SEPC:    sepc    <= cur.src;
                    SLOT_VENDOR:  vendor  <= cur.src;
                    SLOT_MSTATUS: mstatus <= cur.src;
                    SLOT_MEPC:    mepc    <= cur.src;
                    SLOT_PMPCFG:  pmpcfg  <= cur.src;
                    default:      mem_vld[cur.slot] <= 1'b1;
                  endcase
                  if ((cur.slot == SLOT_PMPCFG) || (cur.slot == SLOT_PMPADDR0) ||
                      (cur.slot == SLOT_PMPADDR1)) begin
                    pmp_active     <= tor;
                    restricted_map <= tor && (mode != MODE_MACHINE);
                  end
                end
              end
            endcase
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "guest_csr_trap_emulator_core_macros.svh"

  `GCTE_ASSERT_IMP(a_kill_status, clk, rst, out_valid, killed == (status != ST_OK))
  `GCTE_ASSERT_IMP(a_reset_kills, clk, rst, out_valid && state_reset, killed)
  `GCTE_ASSERT_IMP(a_reset_machine, clk, rst, out_valid && state_reset,
                   privilege == MODE_MACHINE)
  `GCTE_ASSERT_IMP(a_wb_ok, clk, rst, out_valid && write_enable, !killed)
  `GCTE_ASSERT_NXT(a_one_exec, clk, rst, state == S_EXEC, out_valid)

endmodule

>>> sv/guest_csr_trap_emulator_core.sv
// ----------------------------------------------------------------------------
// guest_csr_trap_emulator_core
// Emulates trapped CSR accesses, ecall, sret and mret against a guest CSR set.
// ----------------------------------------------------------------------------
// Input channel: drive the instruction fields and raise push; the item is
// taken on a clock edge where push is high and full is low. The front end
// decodes it and places it in a two-entry queue.
// Result channel: while empty is low the oldest result sits on the result
// ports; pop on a clock edge with empty low takes it.
// When the block is idle, an accepted item passes the queue, the storage
// read and execute before its result shows up on the result ports.
// Items are not overlapped: the back end reads, executes, then the result
// must be popped before the back end takes the next item from the queue.
// If the result is not taken, the back end holds and the queue absorbs two
// more items before full rises.
// Reset puts all CSRs to zero except the vendor id, privilege to machine and
// the PMP flag to zero; a failed CSR access or illegal opcode does the same.
// ----------------------------------------------------------------------------
module guest_csr_trap_emulator_core
  import gcte_pkg::*;
#(
  parameter int PMP_ENTRIES = PMP_ENTRIES_DEF
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  opcode,
  input  logic [11:0] csr_addr,
  input  logic [63:0] source_value,
  input  logic [4:0]  dest_index,
  input  logic [63:0] current_pc,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status,
  output logic        killed,
  output logic        state_reset,
  output logic        write_enable,
  output logic [4:0]  write_index,
  output logic [63:0] write_value,
  output logic [63:0] next_pc,
  output logic [1:0]  privilege,
  output logic        restricted_map
);

  work_t work;
  work_t q_data;
  logic  q_empty;
  logic  q_pop;

  gcte_front u_front (
    .opcode       (opcode),
    .csr_addr     (csr_addr),
    .source_value (source_value),
    .dest_index   (dest_index),
    .current_pc   (current_pc),
    .work         (work)
  );

  gcte_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (work),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  gcte_back #(
    .PmpEntries (PMP_ENTRIES)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_data         (q_data),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .status         (status),
    .killed         (killed),
    .state_reset    (state_reset),
    .write_enable   (write_enable),
    .write_index    (write_index),
    .write_value    (write_value),
    .next_pc        (next_pc),
    .privilege      (privilege),
    .restricted_map (restricted_map)
  );

endmodule
